/* src/tsig_pkg.sv */
`default_nettype none

package tsig_pkg;

	// default field widths of the packed id
	localparam int unsigned GROUP_WIDTH_DEF    = 10;
	localparam int unsigned INDEX_WIDTH_DEF    = 10;
	localparam int unsigned SEQUENCE_WIDTH_DEF = 13;

	// fixed widths of the ports and of the stored time
	localparam int unsigned REQ_WIDTH   = 32;
	localparam int unsigned TIME_WIDTH  = 32;
	localparam int unsigned STAMP_WIDTH = 33;
	localparam int unsigned ID_WIDTH    = 64;

	// base time after reset
	localparam logic [TIME_WIDTH-1:0] EPOCH_RESET = 32'd1625097600;

	// control sequencer
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage : tsig_pkg

`default_nettype wire

/* src/tsig_mod_reduce.sv */
`default_nettype none

// reduces a request word modulo 2^W - 1 by end-around folding of W-bit digits
module tsig_mod_reduce #(
	parameter int unsigned W = tsig_pkg::GROUP_WIDTH_DEF
) (
	input  wire logic [tsig_pkg::REQ_WIDTH-1:0] value,
	output logic      [W-1:0]                   residue
);

	localparam int unsigned NCHUNK = (tsig_pkg::REQ_WIDTH + W - 1) / W;
	localparam int unsigned PADW   = NCHUNK * W;
	localparam int unsigned SUMW   = W + $clog2(NCHUNK);

	logic [PADW-1:0] padded;
	logic [SUMW-1:0] digit_sum;
	logic [W:0]      fold1;
	logic [W-1:0]    fold2;

	assign padded = PADW'(value);

	// sum of the digits, each digit weighs 1 modulo 2^W - 1
	always_comb begin
		digit_sum = '0;
		for (int i = 0; i < NCHUNK; i++) begin
			digit_sum = digit_sum + SUMW'(padded[i*W +: W]);
		end
	end

	// fold the carries back in twice, then map all ones to zero
	assign fold1   = (W+1)'(digit_sum[W-1:0]) + (W+1)'(digit_sum[SUMW-1:W]);
	assign fold2   = fold1[W-1:0] + W'(fold1[W]);
	assign residue = (&fold2) ? '0 : fold2;

endmodule : tsig_mod_reduce

`default_nettype wire

/* src/timestamp_sequence_id_generator_core.sv */
// an accepted request moves to the update step, which loads its id into the output register;
// no new request is taken until the update step ends (counter memory read, update, write)
// the result sits in an output register; a stalled result holds the update step
// reset: epoch returns to its default, last time to zero, and a clearing pass zeroes all
// 2^GROUP_WIDTH entries of the counter memory before the first request is taken
`default_nettype none

module timestamp_sequence_id_generator_core #(
	parameter int unsigned GROUP_WIDTH    = tsig_pkg::GROUP_WIDTH_DEF,
	parameter int unsigned INDEX_WIDTH    = tsig_pkg::INDEX_WIDTH_DEF,
	parameter int unsigned SEQUENCE_WIDTH = tsig_pkg::SEQUENCE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_write,
	input  wire logic [tsig_pkg::TIME_WIDTH-1:0]   epoch_seconds,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [tsig_pkg::REQ_WIDTH-1:0]    group_request,
	input  wire logic [tsig_pkg::REQ_WIDTH-1:0]    index_request,
	input  wire logic [tsig_pkg::TIME_WIDTH-1:0]   now_seconds,
	// id channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [tsig_pkg::ID_WIDTH-1:0]     unique_id
);

	localparam int unsigned DEPTH    = 1 << GROUP_WIDTH;
	localparam int unsigned LOW_W    = GROUP_WIDTH + INDEX_WIDTH;
	localparam int unsigned SHIFT    = LOW_W + SEQUENCE_WIDTH;
	localparam int unsigned TDIFF_W  = tsig_pkg::ID_WIDTH - SHIFT;
	localparam int unsigned STAMP_W  = tsig_pkg::STAMP_WIDTH;
	localparam int unsigned ID_W     = tsig_pkg::ID_WIDTH;

	tsig_pkg::state_t state_q, state_d;

	logic [GROUP_WIDTH-1:0]          clr_cnt_q;
	logic [tsig_pkg::TIME_WIDTH-1:0] epoch_q;
	logic [STAMP_W-1:0]              last_q;

	logic [GROUP_WIDTH-1:0]          grp_mod;
	logic [INDEX_WIDTH-1:0]          idx_mod;
	logic [GROUP_WIDTH-1:0]          grp_s1;
	logic [INDEX_WIDTH-1:0]          idx_s1;
	logic [tsig_pkg::TIME_WIDTH-1:0] now_s1;

	logic [SEQUENCE_WIDTH-1:0]       seq_mem [DEPTH];
	logic [SEQUENCE_WIDTH-1:0]       rd_data_s1;

	logic                            in_acc;
	logic                            upd_go;
	logic                            time_adv;
	logic [SEQUENCE_WIDTH-1:0]       seq_inc;
	logic                            seq_sat;
	logic [SEQUENCE_WIDTH-1:0]       seq_new;
	logic [STAMP_W-1:0]              last_new;
	logic [ID_W-1:0]                 diff_full;

	logic                            out_valid_q;
	logic [ID_W-1:0]                 unique_id_q;

	// reduce group and index modulo 2^W - 1
	tsig_mod_reduce #(.W(GROUP_WIDTH)) u_grp_reduce (
		.value   (group_request),
		.residue (grp_mod)
	);

	tsig_mod_reduce #(.W(INDEX_WIDTH)) u_idx_reduce (
		.value   (index_request),
		.residue (idx_mod)
	);

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		upd_go   = 1'b0;
		unique case (state_q)
			tsig_pkg::ST_CLEAR: begin
				if (&clr_cnt_q) begin
					state_d = tsig_pkg::ST_IDLE;
				end
			end
			tsig_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = tsig_pkg::ST_UPDATE;
				end
			end
			tsig_pkg::ST_UPDATE: begin
				// wait while the previous id is still held at the output
				if (!out_valid_q || !out_stall) begin
					upd_go  = 1'b1;
					state_d = tsig_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsig_pkg::ST_CLEAR;
			end
		endcase
	end

	assign in_acc = in_valid && !in_stall;

	// state register and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tsig_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tsig_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// epoch register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= tsig_pkg::EPOCH_RESET;
		end else if (cfg_write) begin
			epoch_q <= epoch_seconds;
		end
	end

	// capture of the accepted transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			grp_s1 <= grp_mod;
			idx_s1 <= idx_mod;
			now_s1 <= now_seconds;
		end
	end

	// counter memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == tsig_pkg::ST_CLEAR) begin
			seq_mem[clr_cnt_q] <= '0;
		end else if (upd_go) begin
			seq_mem[grp_s1] <= seq_new;
		end
		if (in_acc) begin
			rd_data_s1 <= seq_mem[grp_mod];
		end
	end

	// sequence and time update
	assign time_adv = {1'b0, now_s1} > last_q;
	assign seq_inc  = rd_data_s1 + 1'b1;
	assign seq_sat  = &seq_inc;
	assign seq_new  = (time_adv || seq_sat) ? '0 : seq_inc;

	always_comb begin
		if (time_adv) begin
			last_new = {1'b0, now_s1};
		end else if (seq_sat) begin
			last_new = {1'b0, now_s1} + 1'b1;
		end else begin
			last_new = last_q;
		end
	end

	assign diff_full = ID_W'(last_new) - ID_W'(epoch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (upd_go) begin
			last_q <= last_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			unique_id_q <= {diff_full[TDIFF_W-1:0], seq_new, idx_s1, grp_s1};
		end
	end

	assign out_valid = out_valid_q;
	assign unique_id = unique_id_q;

`ifndef SYNTHESIS
	// an accepted transaction always moves on to the update step
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == tsig_pkg::ST_UPDATE)
		else $error("accepted transaction did not reach the update step");

	// the update step holds while the output register is blocked
	a_update_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsig_pkg::ST_UPDATE && out_valid_q && out_stall
		|=> state_q == tsig_pkg::ST_UPDATE)
		else $error("update step overran a stalled id");

	// the saturation value never appears as a sequence number
	a_seq_not_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(&unique_id_q[SHIFT-1:LOW_W]))
		else $error("sequence field at its saturation value");

	// time advance takes the request time and restarts the sequence
	a_time_adv: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go && time_adv
		|=> last_q == {1'b0, $past(now_s1)} && unique_id_q[SHIFT-1:LOW_W] == '0)
		else $error("time advance not applied");
`endif

endmodule : timestamp_sequence_id_generator_core

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GROUP_MOD   = (1 << tsig_pkg::GROUP_WIDTH_DEF) - 1;
	localparam int unsigned INDEX_MOD   = (1 << tsig_pkg::INDEX_WIDTH_DEF) - 1;
	localparam int unsigned SEQ_SHIFT   = tsig_pkg::INDEX_WIDTH_DEF + tsig_pkg::GROUP_WIDTH_DEF;
	localparam int unsigned STAMP_SHIFT = tsig_pkg::SEQUENCE_WIDTH_DEF + SEQ_SHIFT;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [tsig_pkg::SEQUENCE_WIDTH_DEF-1:0] SEQ_TOP = '1;

	typedef enum logic {
		ROW_REQ,
		ROW_EPOCH
	} row_kind_t;

	// tval is the request time for a request row, the new epoch for an epoch row
	typedef struct packed {
		row_kind_t    kind;
		logic [31:0]  grp;
		logic [31:0]  idx;
		logic [31:0]  tval;
		logic         fixed;
		logic [63:0]  id;
	} row_t;

	localparam row_t DIRECTED [15] = '{
		'{ROW_REQ, 32'd0, 32'd0, tsig_pkg::EPOCH_RESET, 1'b1, 64'h0},
		'{ROW_REQ, 32'd0, 32'd0, tsig_pkg::EPOCH_RESET, 1'b1, 64'h0000_0000_0010_0000},
		'{ROW_REQ, 32'd1022, 32'd1022, tsig_pkg::EPOCH_RESET, 1'b1, 64'h0000_0000_001F_FBFE},
		'{ROW_REQ, 32'd1023, 32'd1023, tsig_pkg::EPOCH_RESET, 1'b1, 64'h0000_0000_0020_0000},
		'{ROW_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, tsig_pkg::EPOCH_RESET + 32'd1, 1'b1,
			64'h0000_0002_0000_0C03},
		'{ROW_REQ, 32'd0, 32'd5, tsig_pkg::EPOCH_RESET + 32'd1, 1'b0, 64'h0},
		'{ROW_REQ, 32'd0, 32'd0, 32'd0, 1'b0, 64'h0},
		'{ROW_REQ, 32'd3, 32'd7, tsig_pkg::EPOCH_RESET + 32'd2, 1'b0, 64'h0},
		'{ROW_REQ, 32'd0, 32'd7, tsig_pkg::EPOCH_RESET + 32'd2, 1'b0, 64'h0},
		'{ROW_EPOCH, 32'd0, 32'd0, 32'd0, 1'b0, 64'h0},
		'{ROW_REQ, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1,
			64'hFFFF_FFFE_0000_0402},
		'{ROW_REQ, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0, 64'h0},
		'{ROW_EPOCH, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 64'h0},
		'{ROW_REQ, 32'd1, 32'd1, 32'd0, 1'b0, 64'h0},
		'{ROW_REQ, 32'd2046, 32'd1, 32'hFFFF_FFFE, 1'b0, 64'h0}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_write     = 1'b0;
	logic [31:0] epoch_seconds = tsig_pkg::EPOCH_RESET;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [31:0] group_request = '0;
	logic [31:0] index_request = '0;
	logic [31:0] now_seconds   = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [63:0] unique_id;

	// predictor state
	logic [31:0]                             epoch_q;
	logic [tsig_pkg::STAMP_WIDTH-1:0]        stamp_q;
	logic [tsig_pkg::SEQUENCE_WIDTH_DEF-1:0] seq_count [1 << tsig_pkg::GROUP_WIDTH_DEF];

	logic [63:0] pending_ids [$];
	int unsigned fail_count = 0;
	int unsigned cyc        = 0;
	int unsigned stall_left = 0;
	bit          calm       = 1'b0;

	wire in_quiet  = (cyc[9:8] == 2'b01);
	wire out_quiet = (cyc[8:7] == 2'b11);

	timestamp_sequence_id_generator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.epoch_seconds (epoch_seconds),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.group_request (group_request),
		.index_request (index_request),
		.now_seconds   (now_seconds),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.unique_id     (unique_id)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// id of one request; updates the stored time and the group's counter
	function automatic logic [63:0] next_unique_id(input logic [31:0] g_req,
			input logic [31:0] i_req, input logic [31:0] now);
		logic [tsig_pkg::GROUP_WIDTH_DEF-1:0]    grp;
		logic [tsig_pkg::INDEX_WIDTH_DEF-1:0]    idx;
		logic [tsig_pkg::SEQUENCE_WIDTH_DEF-1:0] seq;
		logic [63:0]                             span;
		grp = tsig_pkg::GROUP_WIDTH_DEF'(g_req % GROUP_MOD);
		idx = tsig_pkg::INDEX_WIDTH_DEF'(i_req % INDEX_MOD);
		if ({1'b0, now} > stamp_q) begin
			seq_count[grp] = '0;
			stamp_q = {1'b0, now};
			seq = '0;
		end else begin
			seq = seq_count[grp] + 1'b1;
			// counter full: restart and push the time one second past now
			if (seq == SEQ_TOP) begin
				seq_count[grp] = '0;
				stamp_q = {1'b0, now} + 33'd1;
				seq = '0;
			end else begin
				seq_count[grp] = seq;
			end
		end
		span = 64'(stamp_q) - 64'(epoch_q);
		return (span << STAMP_SHIFT) | (64'(seq) << SEQ_SHIFT) |
			(64'(idx) << tsig_pkg::GROUP_WIDTH_DEF) | 64'(grp);
	endfunction

	// one request transaction, with an optional idle burst ahead of it
	task automatic send_request(input logic [31:0] g, input logic [31:0] i,
			input logic [31:0] n, input logic fixed, input logic [63:0] fixed_id);
		logic [63:0] predicted;
		if (!calm && !in_quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		group_request <= g;
		index_request <= i;
		now_seconds   <= n;
		do @(posedge clk); while (in_stall);
		predicted = next_unique_id(g, i, n);
		pending_ids.insert(pending_ids.size(), fixed ? fixed_id : predicted);
	endtask

	// hold off until every id has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_ids.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_epoch(input logic [31:0] value);
		settle();
		cfg_write     <= 1'b1;
		epoch_seconds <= value;
		@(posedge clk);
		epoch_q = value;
		cfg_write <= 1'b0;
	endtask

	// random requests: a few busy groups and times around the stored time
	task automatic random_requests(input int unsigned count);
		logic [31:0] pool [4];
		logic [31:0] g;
		logic [31:0] i;
		logic [31:0] n;
		logic [31:0] base;
		int unsigned r;
		foreach (pool[p]) pool[p] = $urandom;
		repeat (count) begin
			base = stamp_q[32] ? 32'hFFFF_FFFF : stamp_q[31:0];
			g = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 3)] : $urandom;
			case ($urandom_range(0, 9))
				0: i = 32'd0;
				1: i = 32'd1023;
				2: i = 32'hFFFF_FFFF;
				default: i = $urandom;
			endcase
			r = $urandom_range(0, 19);
			if (r < 8)
				n = base;
			else if (r < 13)
				n = base + $urandom_range(1, 2);
			else if (r < 17)
				n = base - $urandom_range(1, 50);
			else if (r < 18)
				n = $urandom;
			else
				n = $urandom_range(0, 3);
			send_request(g, i, n, 1'b0, '0);
		end
	endtask

	// receiver back-pressure in bursts, with quiet windows
	always @(posedge clk) begin
		if (calm || out_quiet) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 7);
		end
	end

	// compare each id transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ids.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected id %h with nothing pending", unique_id);
			end else begin
				if (unique_id !== pending_ids[0]) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("id mismatch: expected %h, got %h", pending_ids[0], unique_id);
				end
				void'(pending_ids.pop_front());
			end
		end
	end

	initial begin
		epoch_q = tsig_pkg::EPOCH_RESET;
		stamp_q = '0;
		foreach (seq_count[s]) seq_count[s] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_EPOCH)
				write_epoch(DIRECTED[r].tval);
			else
				send_request(DIRECTED[r].grp, DIRECTED[r].idx, DIRECTED[r].tval,
					DIRECTED[r].fixed, DIRECTED[r].id);
		end

		// random part under several epochs, last one without idling
		random_requests(340);
		write_epoch($urandom);
		random_requests(340);
		write_epoch(32'd0);
		random_requests(340);
		calm = 1'b1;
		write_epoch(tsig_pkg::EPOCH_RESET);
		random_requests(330);

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_ids.size() == 0)
			$display("** timestamp_sequence_id_generator_core: PASSED **");
		else
			$display("** timestamp_sequence_id_generator_core: FAILED **");
		$finish;
	end

	initial begin
		#25ms;
		$display("** timestamp_sequence_id_generator_core: FAILED **");
		$finish;
	end

endmodule : tb_top

`default_nettype wire

/* timestamp_sequence_id_generator_core.f */
src/tsig_pkg.sv
src/tsig_mod_reduce.sv
src/timestamp_sequence_id_generator_core.sv
dv/tb_top.sv
